[sv/rcc_pkg.sv]
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared widths, limits and interface structs of the random contraction cut
// counter.
// ----------------------------------------------------------------------------
`default_nettype none

package rcc_pkg;

  localparam int unsigned MAX_VERTICES = 256;
  localparam int unsigned VERTEX_W     = 8;
  localparam int unsigned VCOUNT_W     = 9;
  localparam int unsigned CUT_W        = 13;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 9'd2;
  localparam logic [VCOUNT_W-1:0] VCOUNT_LIMIT = VCOUNT_W'(MAX_VERTICES);
  localparam logic [VCOUNT_W-1:0] VCOUNT_SPAN  = 9'd2;
  localparam logic [CUT_W-1:0]    CUT_MAX      = '1;

  typedef logic [VERTEX_W-1:0] vertex_t;

  typedef struct packed {
    logic    en;
    logic    clear;
    vertex_t addr;
    vertex_t data;
  } store_wr_t;

  typedef struct packed {
    logic    done;
    vertex_t root;
  } find_rsp_t;

endpackage

`default_nettype wire

[sv/rcc_ram.sv]
// ----------------------------------------------------------------------------
// rcc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/rcc_store.sv]
// ----------------------------------------------------------------------------
// rcc_store
// Disjoint-set parent store: a RAM plus one valid bit per vertex, so that an
// entry never written since the last clear reads as its own index.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_store (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rcc_pkg::vertex_t  rd_addr,
  output rcc_pkg::vertex_t       rd_data,
  input  wire rcc_pkg::store_wr_t wr
);

  logic [rcc_pkg::MAX_VERTICES-1:0] valid;
  logic                             valid_q;
  rcc_pkg::vertex_t                 addr_q;
  rcc_pkg::vertex_t                 ram_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.clear) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    addr_q  <= rd_addr;
    valid_q <= valid[rd_addr];
  end

  rcc_ram #(
    .WIDTH (rcc_pkg::VERTEX_W),
    .DEPTH (rcc_pkg::MAX_VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign rd_data = valid_q ? ram_q : addr_q;

endmodule

`default_nettype wire

[sv/rcc_find.sv]
// ----------------------------------------------------------------------------
// rcc_find
// Root walker: follows parent links through the store, one link per cycle,
// until it reaches a vertex that is its own parent.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_find (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire rcc_pkg::vertex_t vertex,
  output rcc_pkg::vertex_t      rd_addr,
  input  wire rcc_pkg::vertex_t rd_data,
  output rcc_pkg::find_rsp_t    rsp
);

  logic             busy;
  rcc_pkg::vertex_t cur;
  logic             at_root;

  assign at_root  = (rd_data == cur);
  assign rd_addr  = start ? vertex : rd_data;
  assign rsp.done = busy && at_root;
  assign rsp.root = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && at_root) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= vertex;
    end else if (busy && !at_root) begin
      cur <= rd_data;
    end
  end

endmodule

`default_nettype wire

[sv/random_contraction_cut_counter.sv]
// ----------------------------------------------------------------------------
// random_contraction_cut_counter
// One contraction trial per edge stream: merges sets until two remain, then
// counts the edges that cross between the remaining sets.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       sink       in_valid/in_ready     first_vertex, second_vertex, last
//  out      source     out_valid/out_ready   cut_size, not_reduced
//  cfg      sink       cfg_valid/cfg_ready   vertex_count
//
// An edge passes through FIND_A, FIND_B and UPDATE, walking from each endpoint
// to its root in the parent forest; the last edge of a trial then passes EMIT.
// The single read port of the parent memory walks one link per cycle.
// Reset is synchronous; the parent store comes out of reset as identity.
// A result waiting on out_ready holds the block after the last edge only.
`default_nettype none

module random_contraction_cut_counter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rcc_pkg::VERTEX_W-1:0]  first_vertex,
  input  wire logic [rcc_pkg::VERTEX_W-1:0]  second_vertex,
  input  wire logic                          last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [rcc_pkg::CUT_W-1:0]     cut_size,
  output logic                               not_reduced,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rcc_pkg::VCOUNT_W-1:0]  vertex_count
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FIND_A = 5'b00010,
    ST_FIND_B = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic [rcc_pkg::VCOUNT_W-1:0]   vcount;
  rcc_pkg::vertex_t               b_q;
  logic                           last_q;
  rcc_pkg::vertex_t               root_a;
  rcc_pkg::vertex_t               root_b;
  logic [rcc_pkg::VERTEX_W-1:0]   merges_done;
  logic [rcc_pkg::CUT_W-1:0]      crossing_count;

  logic [rcc_pkg::VCOUNT_W-1:0]   vcount_clamped;
  logic [rcc_pkg::VCOUNT_W-1:0]   need;
  logic                           merging;
  logic                           accept;
  logic                           out_free;
  logic                           find_start;
  rcc_pkg::vertex_t               find_vertex;
  rcc_pkg::vertex_t               rd_addr;
  rcc_pkg::vertex_t               rd_data;
  rcc_pkg::find_rsp_t             find_rsp;
  rcc_pkg::store_wr_t             store_wr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign vcount_clamped = (vcount > rcc_pkg::VCOUNT_LIMIT) ? rcc_pkg::VCOUNT_LIMIT : vcount;
  assign need = (vcount_clamped >= rcc_pkg::VCOUNT_SPAN) ?
                (vcount_clamped - rcc_pkg::VCOUNT_SPAN) : '0;
  assign merging = ({1'b0, merges_done} < need);

  assign find_start  = accept || ((state == ST_FIND_A) && find_rsp.done);
  assign find_vertex = accept ? first_vertex : b_q;

  always_comb begin
    store_wr.en    = (state == ST_UPDATE) && (root_a != root_b) && merging;
    store_wr.clear = (state == ST_EMIT) && out_free;
    store_wr.addr  = root_a;
    store_wr.data  = root_b;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_FIND_A;
        end
      end
      ST_FIND_A: begin
        if (find_rsp.done) begin
          state_next = ST_FIND_B;
        end
      end
      ST_FIND_B: begin
        if (find_rsp.done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      vcount         <= rcc_pkg::VCOUNT_RESET;
      merges_done    <= '0;
      crossing_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        vcount <= vertex_count;
      end
      if (state == ST_UPDATE && root_a != root_b) begin
        if (merging) begin
          merges_done <= merges_done + 1'b1;
        end else if (crossing_count != rcc_pkg::CUT_MAX) begin
          crossing_count <= crossing_count + 1'b1;
        end
      end
      if (state == ST_EMIT && out_free) begin
        out_valid      <= 1'b1;
        merges_done    <= '0;
        crossing_count <= '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_q    <= second_vertex;
      last_q <= last;
    end
    if (state == ST_FIND_A && find_rsp.done) begin
      root_a <= find_rsp.root;
    end
    if (state == ST_FIND_B && find_rsp.done) begin
      root_b <= find_rsp.root;
    end
    if (state == ST_EMIT && out_free) begin
      cut_size    <= merging ? '0 : crossing_count;
      not_reduced <= merging;
    end
  end

  rcc_find u_find (
    .clk     (clk),
    .rst     (rst),
    .start   (find_start),
    .vertex  (find_vertex),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rsp     (find_rsp)
  );

  rcc_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (store_wr)
  );

endmodule

`default_nettype wire

[sv/rcc_checker.sv]
// ----------------------------------------------------------------------------
// rcc_checker
// Port-level checks of the random contraction cut counter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [rcc_pkg::CUT_W-1:0]    cut_size,
  input wire logic                         not_reduced
);

  // Accepting an edge request drops in_ready, as the state register leaves IDLE.
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready right after accepting an edge request");

  a_not_reduced_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && not_reduced |-> cut_size == '0)
    else $error("unreduced trial reported a nonzero cut");

  // A result is produced only as the trial ends, which frees the input side.
  a_rise_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while an edge was still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cut_size) && $stable(not_reduced))
    else $error("stalled result changed or dropped");

endmodule

bind random_contraction_cut_counter rcc_checker u_rcc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .cut_size    (cut_size),
  .not_reduced (not_reduced)
);

`default_nettype wire
